FILE: rtl/core/tsr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsr_pkg
// Shared constants and types of the triangle span rasterizer.
// ----------------------------------------------------------------------------
package tsr_pkg;

  localparam int SCREEN_WIDTH  = 128;
  localparam int SCREEN_HEIGHT = 64;

  localparam int ROW_W   = 6;   // row field width
  localparam int COL_W   = 8;   // column field width
  localparam int COLOR_W = 32;
  localparam int SLOPE_W = 33;  // signed Q16.16 slope
  localparam int OPB_W   = 18;  // signed dy or row-centre offset
  localparam int RES_W   = 49;  // signed result of the iterative unit
  localparam int XQ_W    = 52;  // signed edge x, unit 2^-20 pixel
  localparam int FRAC_Q  = 20;  // fractional bits of the edge x

  typedef enum logic {
    OP_DIV = 1'b0,
    OP_MUL = 1'b1
  } op_t;

  typedef struct packed {
    logic start;
    op_t  op;
  } iter_ctl_t;

endpackage

FILE: rtl/core/tsr_iter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsr_iter
// Shared serial unit: one bit per cycle restoring divide or shift-add multiply.
// ----------------------------------------------------------------------------
module tsr_iter (
  input  logic                               clk,
  input  logic                               rst,
  input  tsr_pkg::iter_ctl_t                 ctl,
  input  logic signed [tsr_pkg::SLOPE_W-1:0] opa,   // dx or slope
  input  logic signed [tsr_pkg::OPB_W-1:0]   opb,   // dy or row offset
  output logic signed [tsr_pkg::RES_W-1:0]   res,
  output logic                               done
);

  typedef enum logic [1:0] {U_IDLE, U_RUN, U_FIN} ustate_t;

  ustate_t     state;
  tsr_pkg::op_t op;
  logic [5:0]  cnt;
  logic [31:0] sh;
  logic [16:0] rem;
  logic [16:0] mb;
  logic [31:0] ma;
  logic [47:0] acc;
  logic        neg;
  logic        zero;

  logic [31:0] mag_a;
  logic [16:0] mag_b;
  logic [18:0] trial;
  logic        ge;

  always_comb begin
    mag_a = opa[tsr_pkg::SLOPE_W-1] ? 32'(-opa) : opa[31:0];
    mag_b = opb[tsr_pkg::OPB_W-1] ? 17'(-opb) : opb[16:0];
    trial = {1'b0, rem, sh[31]} - {2'b0, mb};
    ge    = !trial[18];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= U_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        U_IDLE: begin
          if (ctl.start) begin
            op   <= ctl.op;
            neg  <= opa[tsr_pkg::SLOPE_W-1] ^ opb[tsr_pkg::OPB_W-1];
            zero <= (opb == '0);
            acc  <= '0;
            rem  <= '0;
            ma   <= mag_a;
            mb   <= mag_b;
            if (ctl.op == tsr_pkg::OP_DIV) begin
              sh  <= {mag_a[15:0], 16'b0};
              cnt <= 6'd32;
            end else begin
              sh  <= {mag_b, 15'b0};
              cnt <= 6'd17;
            end
            state <= U_RUN;
          end
        end
        U_RUN: begin
          if (op == tsr_pkg::OP_DIV) begin
            acc <= {acc[46:0], ge};
            rem <= ge ? trial[16:0] : {rem[15:0], sh[31]};
          end else begin
            acc <= {acc[46:0], 1'b0} + (sh[31] ? {16'b0, ma} : 48'b0);
          end
          sh  <= {sh[30:0], 1'b0};
          cnt <= cnt - 6'd1;
          if (cnt == 6'd1) state <= U_FIN;
        end
        U_FIN: begin
          if (op == tsr_pkg::OP_DIV && zero) res <= '0;
          else res <= neg ? -$signed({1'b0, acc}) : $signed({1'b0, acc});
          done  <= 1'b1;
          state <= U_IDLE;
        end
        default: state <= U_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/core/tsr_span.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsr_span
// Round both edge x values to columns, order them and clip to the screen.
// ----------------------------------------------------------------------------
module tsr_span (
  input  logic signed [tsr_pkg::XQ_W-1:0]  xa,
  input  logic signed [tsr_pkg::XQ_W-1:0]  xb,
  output logic        [tsr_pkg::COL_W-1:0] col_lo,
  output logic        [tsr_pkg::COL_W-1:0] col_hi
);

  localparam int XQ_W = tsr_pkg::XQ_W;
  localparam int CW = tsr_pkg::XQ_W - tsr_pkg::FRAC_Q;

  logic signed [tsr_pkg::XQ_W-1:0] ra, rb;
  logic signed [CW-1:0] ca, cb, lo, hi;

  function automatic logic [tsr_pkg::COL_W-1:0] clamp(input logic signed [CW-1:0] c);
    if (c < 0) return '0;
    if (c > CW'(tsr_pkg::SCREEN_WIDTH)) return tsr_pkg::COL_W'(tsr_pkg::SCREEN_WIDTH);
    return c[tsr_pkg::COL_W-1:0];
  endfunction

  always_comb begin
    // add one half pixel, then floor
    ra = xa + (XQ_W'(1) <<< (tsr_pkg::FRAC_Q - 1));
    rb = xb + (XQ_W'(1) <<< (tsr_pkg::FRAC_Q - 1));
    ca = ra[tsr_pkg::XQ_W-1:tsr_pkg::FRAC_Q];
    cb = rb[tsr_pkg::XQ_W-1:tsr_pkg::FRAC_Q];
    lo = (ca > cb) ? cb : ca;
    hi = (ca > cb) ? ca : cb;
    col_lo = clamp(lo);
    col_hi = clamp(hi);
  end

endmodule

FILE: rtl/core/triangle_span_rasterizer_core.sv
`timescale 1ns / 1ps
// Sequence: the first span word follows slope divides S_DIV01, S_DIV02, S_DIV12, then edge-start
//   multiplies S_MUL_A, S_MUL_B on the shared unit; a lower half after an upper one redoes both.
// Throughput: one triangle at a time; s_tready is high only in idle.
// Reset: rst is synchronous, active high; clears the sequencer and the output valid.
// ----------------------------------------------------------------------------
// triangle_span_rasterizer_core
// Sorts a triangle by y, forms edge slopes and emits one span word per row.
// ----------------------------------------------------------------------------
module triangle_span_rasterizer_core (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // ax[15:0] ay[31:16] bx[47:32] by[63:48] cx[79:64] cy[95:80] fill_color[127:96]
  input  logic [127:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // row[5:0] span_start[13:6] span_end[21:14] span_color[53:22], zero pad [55:54]
  output logic [55:0]  m_tdata,
  output logic         m_tlast  // last_span
);

  localparam int ROW_W = tsr_pkg::ROW_W;
  localparam int XQ_W  = tsr_pkg::XQ_W;
  localparam int RY_W  = 13;  // width of a rounded vertex row

  typedef enum logic [2:0] {
    S_IDLE, S_DIV01, S_DIV02, S_DIV12, S_MUL_A, S_MUL_B, S_EMIT
  } state_t;

  state_t state;
  logic   pend;   // unit command issued, waiting for done
  logic   half;   // 0 upper half, 1 lower half

  logic signed [15:0] vx0, vy0, vx1, vy1, vx2, vy2;
  logic [tsr_pkg::COLOR_W-1:0] color;
  logic signed [tsr_pkg::SLOPE_W-1:0] s01, s02, s12;
  logic signed [XQ_W-1:0] xa, xb;
  logic [ROW_W-1:0] r;

  // sort network on the incoming word
  logic signed [15:0] ix [3];
  logic signed [15:0] iy [3];
  logic signed [15:0] tx, ty;

  always_comb begin
    tx = '0;
    ty = '0;
    ix[0] = s_tdata[15:0];  iy[0] = s_tdata[31:16];
    ix[1] = s_tdata[47:32]; iy[1] = s_tdata[63:48];
    ix[2] = s_tdata[79:64]; iy[2] = s_tdata[95:80];
    if (iy[1] < iy[0]) begin
      tx = ix[0]; ty = iy[0]; ix[0] = ix[1]; iy[0] = iy[1]; ix[1] = tx; iy[1] = ty;
    end
    if (iy[2] < iy[1]) begin
      tx = ix[1]; ty = iy[1]; ix[1] = ix[2]; iy[1] = iy[2]; ix[2] = tx; iy[2] = ty;
    end
    if (iy[2] < iy[0]) begin
      tx = ix[0]; ty = iy[0]; ix[0] = ix[2]; iy[0] = iy[2]; ix[2] = tx; iy[2] = ty;
    end
    if (iy[1] < iy[0]) begin
      tx = ix[0]; ty = iy[0]; ix[0] = ix[1]; iy[0] = iy[1]; ix[1] = tx; iy[1] = ty;
    end
  end

  // row ranges of both halves: round(y) = floor((y + 8) / 16)
  logic signed [16:0] y0r, y1r, y2r;
  logic signed [RY_W-1:0] ry0, ry1, ry2, u_first, u_stop, l_first, l_stop;
  logic up_ne, lo_ne;
  logic [ROW_W-1:0] first_row, last_row;

  always_comb begin
    y0r = 17'(vy0) + 17'sd8;
    y1r = 17'(vy1) + 17'sd8;
    y2r = 17'(vy2) + 17'sd8;
    ry0 = y0r[16:4];
    ry1 = y1r[16:4];
    ry2 = y2r[16:4];
    u_first = (ry0 < 0) ? '0 : ry0;
    u_stop  = (ry1 > RY_W'(tsr_pkg::SCREEN_HEIGHT)) ? RY_W'(tsr_pkg::SCREEN_HEIGHT) : ry1;
    l_first = (ry1 < 0) ? '0 : ry1;
    l_stop  = (ry2 > RY_W'(tsr_pkg::SCREEN_HEIGHT)) ? RY_W'(tsr_pkg::SCREEN_HEIGHT) : ry2;
    up_ne   = u_first < u_stop;
    lo_ne   = l_first < l_stop;
    first_row = half ? l_first[ROW_W-1:0] : u_first[ROW_W-1:0];
    last_row  = half ? 6'(l_stop - 1) : 6'(u_stop - 1);
  end

  // operands of the shared unit
  tsr_pkg::iter_ctl_t ctl;
  logic signed [tsr_pkg::SLOPE_W-1:0] opa;
  logic signed [tsr_pkg::OPB_W-1:0]   opb;
  logic signed [tsr_pkg::RES_W-1:0]   res;
  logic done;
  logic signed [15:0] xs, ys;

  always_comb begin
    xs = (state == S_MUL_A && half) ? vx1 : vx0;
    ys = (state == S_MUL_A && half) ? vy1 : vy0;
    ctl.start = 1'b0;
    ctl.op    = tsr_pkg::OP_DIV;
    opa = '0;
    opb = '0;
    case (state)
      S_DIV01: begin
        opa = 33'(18'(vx1) - 18'(vx0)); opb = 18'(vy1) - 18'(vy0);
      end
      S_DIV02: begin
        opa = 33'(18'(vx2) - 18'(vx0)); opb = 18'(vy2) - 18'(vy0);
      end
      S_DIV12: begin
        opa = 33'(18'(vx2) - 18'(vx1)); opb = 18'(vy2) - 18'(vy1);
      end
      S_MUL_A, S_MUL_B: begin
        ctl.op = tsr_pkg::OP_MUL;
        opa = (state == S_MUL_A) ? (half ? s12 : s01) : s02;
        // row centre minus start y, 1/16 pixel
        opb = $signed({8'b0, first_row, 4'b1000}) - 18'(ys);
      end
      default: ;
    endcase
    if (state != S_IDLE && state != S_EMIT && !pend) ctl.start = 1'b1;
  end

  tsr_iter u_iter (
    .clk (clk),
    .rst (rst),
    .ctl (ctl),
    .opa (opa),
    .opb (opb),
    .res (res),
    .done(done)
  );

  logic signed [XQ_W-1:0] x_new;
  assign x_new = $signed({{(XQ_W-32){xs[15]}}, xs, 16'b0}) + XQ_W'(res);

  logic [tsr_pkg::COL_W-1:0] col_lo, col_hi;

  tsr_span u_span (
    .xa    (xa),
    .xb    (xb),
    .col_lo(col_lo),
    .col_hi(col_hi)
  );

  logic out_free;
  logic is_last;
  assign out_free = !m_tvalid || m_tready;
  assign is_last  = (r == last_row) && (half || !lo_ne);
  assign s_tready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      pend     <= 1'b0;
      half     <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      // drop a taken word; in emit the valid is set below whenever the word is free
      if (m_tvalid && m_tready && state != S_EMIT) m_tvalid <= 1'b0;
      if (ctl.start) pend <= 1'b1;
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            vx0 <= ix[0]; vy0 <= iy[0];
            vx1 <= ix[1]; vy1 <= iy[1];
            vx2 <= ix[2]; vy2 <= iy[2];
            color <= s_tdata[127:96];
            half  <= 1'b0;
            state <= S_DIV01;
          end
        end
        S_DIV01: begin
          if (done) begin
            s01 <= res[tsr_pkg::SLOPE_W-1:0]; pend <= 1'b0; state <= S_DIV02;
          end
        end
        S_DIV02: begin
          if (done) begin
            s02 <= res[tsr_pkg::SLOPE_W-1:0]; pend <= 1'b0; state <= S_DIV12;
          end
        end
        S_DIV12: begin
          if (done) begin
            s12  <= res[tsr_pkg::SLOPE_W-1:0];
            pend <= 1'b0;
            if (up_ne) begin
              half <= 1'b0; state <= S_MUL_A;
            end else if (lo_ne) begin
              half <= 1'b1; state <= S_MUL_A;
            end else begin
              state <= S_IDLE;  // degenerate: no spans
            end
          end
        end
        S_MUL_A: begin
          if (done) begin
            xa <= x_new; pend <= 1'b0; state <= S_MUL_B;
          end
        end
        S_MUL_B: begin
          if (done) begin
            xb <= x_new; pend <= 1'b0; r <= first_row; state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {2'b0, color, col_hi, col_lo, r};
            m_tlast  <= is_last;
            // advance both edges by one row: 16 * slope
            xa <= xa + (XQ_W'(half ? s12 : s01) <<< 4);
            xb <= xb + (XQ_W'(s02) <<< 4);
            r  <= r + 1'b1;
            if (r == last_row) begin
              if (!half && lo_ne) begin
                half <= 1'b1; state <= S_MUL_A;
              end else begin
                state <= S_IDLE;
              end
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives triangles into the span rasterizer over the stream input. A
// behavioral span generator in this bench predicts every output word, and a
// scoreboard checks the words in order: a directed table first, then random
// triangles under several idle and stall patterns.
// ----------------------------------------------------------------------------
module tb_top;

  typedef struct packed {
    logic [5:0]  row;
    logic [7:0]  col_lo;
    logic [7:0]  col_hi;
    logic [31:0] color;
    logic        last;
  } span_t;

  typedef struct {
    logic signed [15:0] x[3];
    logic signed [15:0] y[3];
    logic [31:0]        color;
  } tri_t;

  // Directed row: a triangle plus, where obvious, its lone expected span.
  typedef struct {
    tri_t  t;
    bit    has_exp;
    int    n_exp;
    span_t s;
  } drow_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [127:0] s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [55:0]  m_tdata;
  logic         m_tlast;

  span_t span_q[$];
  int    errors = 0;
  int    send_idle_pct = 0;
  int    recv_stall_pct = 0;
  bit    hold_off = 1'b0;

  always #2 clk = ~clk;

  triangle_span_rasterizer_core DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
  );

  // floor(v / 2^n)
  function automatic longint floor_shift(longint v, int n);
    return v >>> n;
  endfunction

  function automatic longint slope_q16(longint dx, longint dy);
    if (dy == 0) return 0;
    return (dx * 65536) / dy;
  endfunction

  function automatic longint round_col(longint xs, longint ys, longint sl, longint r);
    longint xq;
    xq = xs * 65536 + (r * 16 + 8 - ys) * sl;
    return floor_shift(xq + 64'sd524288, 20);
  endfunction

  function automatic longint clip_col(longint c);
    if (c < 0) return 0;
    if (c > tsr_pkg::SCREEN_WIDTH) return tsr_pkg::SCREEN_WIDTH;
    return c;
  endfunction

  // Append the spans of one half of the triangle to the expected queue.
  task automatic queue_half(longint ytop, longint ybot, longint xa, longint ya,
                            longint sa, longint xb, longint yb, longint sb,
                            logic [31:0] color, ref int n);
    longint first, stop, c0, c1, tmp;
    span_t  s;
    first = floor_shift(ytop + 8, 4);
    stop  = floor_shift(ybot + 8, 4);
    if (first < 0) first = 0;
    if (stop > tsr_pkg::SCREEN_HEIGHT) stop = tsr_pkg::SCREEN_HEIGHT;
    for (longint r = first; r < stop && n < 64; r++) begin
      c0 = round_col(xa, ya, sa, r);
      c1 = round_col(xb, yb, sb, r);
      if (c0 > c1) begin
        tmp = c0; c0 = c1; c1 = tmp;
      end
      s.row = r[5:0];
      s.col_lo = 8'(clip_col(c0));
      s.col_hi = 8'(clip_col(c1));
      s.color = color;
      s.last = 1'b0;
      span_q.push_back(s);
      n++;
    end
  endtask

  // Predict all spans of a triangle; returns how many were queued.
  task automatic predict_spans(tri_t t, output int n);
    longint vx[3], vy[3], tmp, s01, s02, s12;
    int pa[4] = '{0, 1, 0, 0};
    int pb[4] = '{1, 2, 2, 1};
    span_t s;
    for (int i = 0; i < 3; i++) begin
      vx[i] = t.x[i];
      vy[i] = t.y[i];
    end
    // fixed compare-and-swap network; equal y keeps input order
    for (int k = 0; k < 4; k++)
      if (vy[pb[k]] < vy[pa[k]]) begin
        tmp = vy[pa[k]]; vy[pa[k]] = vy[pb[k]]; vy[pb[k]] = tmp;
        tmp = vx[pa[k]]; vx[pa[k]] = vx[pb[k]]; vx[pb[k]] = tmp;
      end
    s01 = slope_q16(vx[1] - vx[0], vy[1] - vy[0]);
    s02 = slope_q16(vx[2] - vx[0], vy[2] - vy[0]);
    s12 = slope_q16(vx[2] - vx[1], vy[2] - vy[1]);
    n = 0;
    queue_half(vy[0], vy[1], vx[0], vy[0], s01, vx[0], vy[0], s02, t.color, n);
    queue_half(vy[1], vy[2], vx[1], vy[1], s12, vx[0], vy[0], s02, t.color, n);
    if (n > 0) begin
      s = span_q.pop_back();
      s.last = 1'b1;
      span_q.push_back(s);
    end
  endtask

  function automatic logic [127:0] pack_tri(tri_t t);
    return {t.color, t.y[2], t.x[2], t.y[1], t.x[1], t.y[0], t.x[0]};
  endfunction

  // Send one triangle word; hold valid until it is taken. Valid stays high
  // after the accept until the next idle cycle or drain; the block is busy then.
  task automatic send_tri(tri_t t);
    int n;
    predict_spans(t, n);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= pack_tri(t);
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (span_q.size() != 0);
  endtask

  function automatic tri_t mk(int ax, int ay, int bx, int by, int cx, int cy,
                              logic [31:0] color);
    tri_t t;
    t.x = '{ax[15:0], bx[15:0], cx[15:0]};
    t.y = '{ay[15:0], by[15:0], cy[15:0]};
    t.color = color;
    return t;
  endfunction

  // Mostly on-screen triangles with some wild ones.
  function automatic tri_t rand_tri();
    tri_t t;
    int sel;
    sel = $urandom_range(9);
    for (int i = 0; i < 3; i++) begin
      if (sel < 6) begin
        t.x[i] = 16'($urandom_range(2200) - 100);
        t.y[i] = 16'($urandom_range(1100) - 50);
      end else if (sel < 8) begin
        t.x[i] = 16'($urandom_range(8000) - 4000);
        t.y[i] = 16'($urandom_range(4000) - 2000);
      end else begin
        t.x[i] = 16'($urandom);
        t.y[i] = 16'($urandom);
      end
    end
    // occasional shared y to hit flat tops and bottoms
    if ($urandom_range(7) == 0) t.y[1] = t.y[0];
    if ($urandom_range(7) == 0) t.y[2] = t.y[1];
    t.color = $urandom;
    return t;
  endfunction

  // Receiver: random stalls, plus a long hold-off stretch on request.
  always @(posedge clk) begin
    if (rst || hold_off) m_tready <= 1'b0;
    else m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Scoreboard: check every taken word against the oldest prediction.
  always @(posedge clk) begin
    span_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = {m_tdata[5:0], m_tdata[13:6], m_tdata[21:14], m_tdata[53:22], m_tlast};
      if (span_q.size() == 0) begin
        $display("%0t: unexpected span word %h last %b", $time, m_tdata, m_tlast);
        errors++;
      end else begin
        want = span_q.pop_front();
        if (got.row !== want.row || got.col_lo !== want.col_lo ||
            got.col_hi !== want.col_hi || got.color !== want.color ||
            got.last !== want.last || m_tdata[55:54] !== 2'b00) begin
          $display("%0t: mismatch expected row %0d %0d..%0d col %h last %b", $time,
                   want.row, want.col_lo, want.col_hi, want.color, want.last);
          $display("%0t:          actual   row %0d %0d..%0d col %h last %b", $time,
                   got.row, got.col_lo, got.col_hi, got.color, got.last);
          errors++;
        end
      end
    end
  end

  initial begin
    #40_000_000;
    $display("tb_top: FAIL");
    $finish;
  end

  initial begin
    drow_t dir[$];
    drow_t d;
    int    n;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table. A single-row triangle has an obvious lone span.
    d = '{default: '0};
    // one row, edges at x = 0 and x = 5 px at the row centre: row 0, cols 0..5
    d.t = mk(0, 0, 160, 0, 0, 16, 32'hA5A5_5A5A);
    d.has_exp = 1; d.n_exp = 1; d.s = '{6'd0, 8'd0, 8'd5, 32'hA5A5_5A5A, 1'b1};
    dir.push_back(d);
    // degenerate: all on one row, nothing emitted
    d.t = mk(0, 100, 500, 100, 900, 100, 32'h1); d.has_exp = 1; d.n_exp = 0;
    dir.push_back(d);
    d.has_exp = 0;
    // all zero
    d.t = mk(0, 0, 0, 0, 0, 0, 32'h0); d.has_exp = 1; d.n_exp = 0; dir.push_back(d);
    d.has_exp = 0;
    d.t = mk(-32768, -32768, 32767, 32767, -32768, 32767, 32'hFFFF_FFFF); dir.push_back(d);
    d.t = mk(32767, -32768, -32768, 32767, 32767, 32767, 32'h8000_0001); dir.push_back(d);
    d.t = mk(-32768, 32767, 32767, -32768, 0, 0, 32'h7FFF_FFFE); dir.push_back(d);
    // whole screen covered, wide edges clipped both sides
    d.t = mk(-4000, -200, 6000, -200, 1000, 2000, 32'h1234_5678); dir.push_back(d);
    // flat bottom, flat top, ties kept in input order
    d.t = mk(500, 100, 100, 600, 900, 600, 32'h0000_00FF); dir.push_back(d);
    d.t = mk(100, 100, 900, 100, 500, 600, 32'h0000_FF00); dir.push_back(d);
    d.t = mk(500, 600, 100, 100, 900, 100, 32'h00FF_0000); dir.push_back(d);
    // reversed ends, rounding at exact half columns and rows
    d.t = mk(2000, 8, 40, 24, 1000, 1000, 32'hDEAD_BEEF); dir.push_back(d);
    d.t = mk(8, 8, 2040, 1016, 24, 1016, 32'hCAFE_F00D); dir.push_back(d);
    // wholly off screen left, right, above, below
    d.t = mk(-3000, 100, -2000, 400, -2500, 800, 32'h1); dir.push_back(d);
    d.t = mk(3000, 100, 4000, 400, 3500, 800, 32'h2); dir.push_back(d);
    d.t = mk(100, -3000, 900, -2000, 500, -1500, 32'h3); dir.push_back(d);
    d.t = mk(100, 1100, 900, 1500, 500, 2000, 32'h4); dir.push_back(d);
    // straddling top and bottom edges, thin sliver, big slope
    d.t = mk(300, -50, 900, 1100, 1500, 300, 32'h5); dir.push_back(d);
    d.t = mk(0, 0, 1, 1023, 2, 500, 32'h6); dir.push_back(d);
    d.t = mk(0, 0, 32767, 1, 100, 900, 32'h7); dir.push_back(d);

    foreach (dir[i]) begin
      int before_n;
      // drain first so the queue holds only this triangle's spans
      wait_drained();
      before_n = span_q.size();
      send_tri(dir[i].t);
      if (dir[i].has_exp && span_q.size() - before_n != dir[i].n_exp) begin
        $display("%0t: row %0d expected %0d spans, predicted %0d", $time, i,
                 dir[i].n_exp, span_q.size() - before_n);
        errors++;
      end else if (dir[i].has_exp && dir[i].n_exp == 1 &&
                   span_q[before_n] !== dir[i].s) begin
        $display("%0t: row %0d expected span %h, predicted %h", $time, i,
                 dir[i].s, span_q[before_n]);
        errors++;
      end
    end
    wait_drained();

    // Random phases: none, sender idle, receiver stall, both.
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = (ph == 1 || ph == 3) ? ((ph == 1) ? 59 : 36) : 0;
      recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 2) ? 59 : 36) : 0;
      for (int i = 0; i < 120; i++) send_tri(rand_tri());
      // sender waits for all spans before going on
      wait_drained();
    end

    // Long receiver hold-off while triangles keep coming.
    send_idle_pct = 0; recv_stall_pct = 0;
    fork
      begin
        hold_off = 1'b1;
        repeat (3000) @(posedge clk);
        hold_off = 1'b0;
      end
      for (int i = 0; i < 20; i++) send_tri(rand_tri());
    join
    wait_drained();
    repeat (300) @(posedge clk);

    if (errors == 0 && span_q.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
